/* rtl/core/fstm_pkg.sv */
package fstm_pkg;

    // time fields and configuration registers
    localparam int TIME_BITS = 24;
    // step accumulator holds one time value plus a carry
    localparam int ACC_W     = TIME_BITS + 1;
    // frame and window-time counters
    localparam int CNT_W     = 32;
    // reported rate
    localparam int RATE_W    = 16;
    // frames * window
    localparam int PROD_W    = CNT_W + TIME_BITS;
    // divider step counter, holds up to ACC_W
    localparam int DCNT_W    = $clog2(ACC_W + 1);

    localparam logic [TIME_BITS-1:0] FIXED_STEP_RST  = TIME_BITS'(16667);
    localparam logic [TIME_BITS-1:0] RATE_WINDOW_RST = TIME_BITS'(1000000);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_METER,
        S_OVF,
        S_RDIV,
        S_RFIN,
        S_TLOAD,
        S_TDIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;     // take the word, update counters and step sum
        logic mul;        // register frames * window
        logic rate_sat;   // quotient overflows, report saturated rate
        logic rdiv_load;  // load divider for the rate
        logic rate_done;  // store rate, clear window counters
        logic tdiv_load;  // load divider for the tick count
        logic div_step;   // one restoring division step
        logic out_load;   // fill output register, keep remainder
    } t_cmd;

    typedef struct packed {
        logic over_window;
        logic rate_ovf;
        logic div_last;
    } t_stat;

endpackage

/* rtl/core/fstm_ctrl.sv */
module fstm_ctrl
    import fstm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_METER;
                end
            end
            S_METER: begin
                if (i_stat.over_window) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_OVF;
                end else begin
                    n_state = S_TLOAD;
                end
            end
            S_OVF: begin
                if (i_stat.rate_ovf) begin
                    o_cmd.rate_sat = 1'b1;
                    n_state        = S_TLOAD;
                end else begin
                    o_cmd.rdiv_load = 1'b1;
                    n_state         = S_RDIV;
                end
            end
            S_RDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RFIN;
                end
            end
            S_RFIN: begin
                o_cmd.rate_done = 1'b1;
                n_state         = S_TLOAD;
            end
            S_TLOAD: begin
                o_cmd.tdiv_load = 1'b1;
                n_state         = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/fstm_dpath.sv */
module fstm_dpath
    import fstm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [TIME_BITS-1:0] i_delta_us,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_BITS-1:0] i_cfg_wdata,
    output logic [TIME_BITS-1:0] o_ticks_due,
    output logic [RATE_W-1:0]    o_frame_rate,
    output logic                 o_rate_updated
);

    logic [TIME_BITS-1:0] r_fixed_step;
    logic [TIME_BITS-1:0] r_rate_window;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_frames;
    logic [CNT_W-1:0]     r_time;
    logic [RATE_W-1:0]    r_last_rate;
    logic                 r_updated;
    logic [ACC_W-1:0]     r_sum;
    logic [PROD_W-1:0]    r_prod;

    // shared restoring divider
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [ACC_W-1:0]     r_dvd;
    logic [ACC_W-1:0]     r_quo;
    logic [DCNT_W-1:0]    r_cnt;

    logic [TIME_BITS-1:0] r_o_ticks;
    logic [RATE_W-1:0]    r_o_rate;
    logic                 r_o_upd;

    logic [TIME_BITS-1:0] step_eff;
    logic [CNT_W-1:0]     frames_inc;
    logic [CNT_W:0]       time_sum;
    logic [CNT_W-1:0]     time_sat;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W+1:0]     trial;
    logic                 borrow;

    // a zero step counts as one microsecond
    assign step_eff = (r_fixed_step == '0) ? TIME_BITS'(1) : r_fixed_step;

    assign frames_inc = (r_frames == '1) ? r_frames : r_frames + CNT_W'(1);
    assign time_sum   = {1'b0, r_time} + (CNT_W + 1)'(i_delta_us);
    assign time_sat   = time_sum[CNT_W] ? '1 : time_sum[CNT_W-1:0];

    assign rem_sh = {r_rem, r_dvd[ACC_W-1]};
    assign trial  = {1'b0, rem_sh} - (CNT_W + 2)'(r_div);
    assign borrow = trial[CNT_W+1];

    assign o_stat.over_window = (r_time > CNT_W'(r_rate_window));
    assign o_stat.rate_ovf    =
        (r_prod[PROD_W-1:RATE_W] >= (PROD_W - RATE_W)'(r_time));
    assign o_stat.div_last    = (r_cnt == DCNT_W'(1));

    // configuration and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_step  <= FIXED_STEP_RST;
            r_rate_window <= RATE_WINDOW_RST;
            r_acc         <= '0;
            r_frames      <= '0;
            r_time        <= '0;
            r_last_rate   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FIXED_STEP:  r_fixed_step  <= i_cfg_wdata;
                    CFG_RATE_WINDOW: r_rate_window <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_frames <= frames_inc;
                r_time   <= time_sat;
            end
            if (i_cmd.rate_sat || i_cmd.rate_done) begin
                r_frames <= '0;
                r_time   <= '0;
            end
            if (i_cmd.rate_sat) begin
                r_last_rate <= '1;
            end
            if (i_cmd.rate_done) begin
                r_last_rate <= r_quo[RATE_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_acc <= ACC_W'(r_rem);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sum     <= r_acc + ACC_W'(i_delta_us);
            r_updated <= 1'b0;
        end
        if (i_cmd.rate_sat || i_cmd.rate_done) begin
            r_updated <= 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_frames) * PROD_W'(r_rate_window);
        end
        if (i_cmd.rdiv_load) begin
            // high part is known to be below the divisor here
            r_rem <= r_prod[CNT_W+RATE_W-1:RATE_W];
            r_dvd <= {r_prod[RATE_W-1:0], (ACC_W - RATE_W)'(0)};
            r_div <= r_time;
            r_quo <= '0;
            r_cnt <= DCNT_W'(RATE_W);
        end else if (i_cmd.tdiv_load) begin
            r_rem <= '0;
            r_dvd <= r_sum;
            r_div <= CNT_W'(step_eff);
            r_quo <= '0;
            r_cnt <= DCNT_W'(ACC_W);
        end else if (i_cmd.div_step) begin
            r_rem <= borrow ? rem_sh[CNT_W-1:0] : trial[CNT_W-1:0];
            r_dvd <= {r_dvd[ACC_W-2:0], 1'b0};
            r_quo <= {r_quo[ACC_W-2:0], ~borrow};
            r_cnt <= r_cnt - DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_o_ticks <= r_quo[ACC_W-1] ? '1 : r_quo[TIME_BITS-1:0];
            r_o_rate  <= r_last_rate;
            r_o_upd   <= r_updated;
        end
    end

    assign o_ticks_due    = r_o_ticks;
    assign o_frame_rate   = r_o_rate;
    assign o_rate_updated = r_o_upd;

endmodule

/* rtl/core/fixed_step_tick_and_fps_meter.sv */
// channel  direction  handshake                 word
// -------  ---------  ------------------------  -------------------------------------
// in       to block   i_in_valid / o_in_stall   i_delta_us
// out      from block o_out_valid / i_out_stall o_ticks_due, o_frame_rate,
//                                                o_rate_updated
// cfg      to block   i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// one word at a time: the next word is taken only after the last is handed over;
// a rate report that saturates skips the rate division, any other goes through it
// the shared restoring divider takes 25 steps for the ticks, 16 for the rate
// synchronous active-low reset loads the default step and window, clears the state
// a finished word waits in the output register; a new word is taken meanwhile, and
// only the final hand-over stalls while that register is still full
module fixed_step_tick_and_fps_meter
    import fstm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TIME_BITS-1:0] i_delta_us,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TIME_BITS-1:0] o_ticks_due,
    output logic [RATE_W-1:0]    o_frame_rate,
    output logic                 o_rate_updated,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_BITS-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: meter check, optional rate division, then tick division
    fstm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // counters, accumulator, multiplier, divider and output register
    fstm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_delta_us     (i_delta_us),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_ticks_due    (o_ticks_due),
        .o_frame_rate   (o_frame_rate),
        .o_rate_updated (o_rate_updated)
    );

endmodule

/* tb/sv/tb_fixed_step_tick_and_fps_meter.sv */
`timescale 1ns / 100ps

module tb_fixed_step_tick_and_fps_meter;
    import fstm_pkg::*;

    // run length guard and the quiet time that follows the last result
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int SEG_WORDS    = 158;
    localparam int MAX_PRINTS   = 40;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam longint unsigned      CNT_SAT  = 64'h0000_0000_FFFF_FFFF;
    localparam longint unsigned      RATE_SAT = 64'h0000_0000_0000_FFFF;

    typedef struct packed {
        logic [TIME_BITS-1:0] ticks;
        logic [RATE_W-1:0]    rate;
        logic                 updated;
    } t_frame_report;

    // block ports, inputs all known from time zero
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [TIME_BITS-1:0] i_delta_us     = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [TIME_BITS-1:0] o_ticks_due;
    logic [RATE_W-1:0]    o_frame_rate;
    logic                 o_rate_updated;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [TIME_BITS-1:0] i_cfg_wdata    = '0;

    // predictor copy of the configuration and of the block state
    logic [TIME_BITS-1:0] cfg_step     = FIXED_STEP_RST;
    logic [TIME_BITS-1:0] cfg_window   = RATE_WINDOW_RST;
    logic [ACC_W-1:0]     step_rem     = '0;
    logic [CNT_W-1:0]     frame_cnt    = '0;
    logic [CNT_W-1:0]     window_time  = '0;
    logic [RATE_W-1:0]    rate_hold    = '0;

    // frame times still to send, and reports still owed by the block
    logic [TIME_BITS-1:0] delta_q[$];
    t_frame_report        frame_reports_q[$];

    int unsigned mismatch_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned snd_idle_pct = 27;
    int unsigned rcv_idle_pct = 59;
    int unsigned quiet_left   = 0;
    bit          delta_taken  = 1'b0;

    fixed_step_tick_and_fps_meter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_delta_us     (i_delta_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ticks_due    (o_ticks_due),
        .o_frame_rate   (o_frame_rate),
        .o_rate_updated (o_rate_updated),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one frame mark through the meter and the step accumulator
    function automatic t_frame_report predict_frame(input logic [TIME_BITS-1:0] delta);
        longint unsigned step;
        longint unsigned frames;
        longint unsigned elapsed;
        longint unsigned rate;
        longint unsigned sum;
        longint unsigned ticks;
        t_frame_report   rep;
        // a zero step behaves as one microsecond
        step = (cfg_step == '0) ? 64'd1 : longint'(cfg_step);
        rep.updated = 1'b0;
        // frame and time counters saturate rather than wrap
        frames  = longint'(frame_cnt) + 1;
        elapsed = longint'(window_time) + longint'(delta);
        if (frames > CNT_SAT)
            frames = CNT_SAT;
        if (elapsed > CNT_SAT)
            elapsed = CNT_SAT;
        // window exceeded: report the rate and start a fresh window
        if (elapsed > longint'(cfg_window)) begin
            rate = (frames * longint'(cfg_window)) / elapsed;
            if (rate > RATE_SAT)
                rate = RATE_SAT;
            rate_hold   = rate[RATE_W-1:0];
            frames      = 0;
            elapsed     = 0;
            rep.updated = 1'b1;
        end
        frame_cnt   = frames[CNT_W-1:0];
        window_time = elapsed[CNT_W-1:0];
        // whole steps out of the accumulator, remainder kept, excess steps lost
        sum      = longint'(step_rem) + longint'(delta);
        ticks    = sum / step;
        step_rem = ACC_W'(sum % step);
        if (ticks > longint'(TIME_MAX))
            ticks = longint'(TIME_MAX);
        rep.ticks = ticks[TIME_BITS-1:0];
        rep.rate  = rate_hold;
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("mismatch on result %0d, %s: got %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    // register write, only ever issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_FIXED_STEP)
            cfg_step = val;
        else
            cfg_window = val;
    endtask

    // wait until every queued word has gone in and every report has come out
    task automatic settle();
        while (delta_q.size() != 0 || i_in_valid || frame_reports_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // frame times: most often around the step, plus zero, near-full-scale, anything and small ones
    function automatic logic [TIME_BITS-1:0] rand_delta();
        int unsigned pick;
        longint      v;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            v = longint'(cfg_step) * longint'($urandom_range(0, 3))
                + longint'($urandom_range(0, 128)) - 64;
            if (v < 0)
                v = 0;
            if (v > longint'(TIME_MAX))
                v = longint'(TIME_MAX);
        end else if (pick < 52) begin
            v = 0;
        end else if (pick < 62) begin
            v = longint'(TIME_MAX) - longint'($urandom_range(0, 3));
        end else if (pick < 82) begin
            v = longint'($urandom_range(0, TIME_MAX));
        end else begin
            v = longint'($urandom_range(1, 1000));
        end
        return v[TIME_BITS-1:0];
    endfunction

    // one random stretch under a given step, window and idling mix
    task automatic run_segment(input logic [TIME_BITS-1:0] step, input logic [TIME_BITS-1:0] win,
                               input int unsigned snd_pct, input int unsigned rcv_pct);
        write_reg(CFG_FIXED_STEP, step);
        write_reg(CFG_RATE_WINDOW, win);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (SEG_WORDS) delta_q.insert(delta_q.size(), rand_delta());
        settle();
    endtask

    // driver: new word or idle at the falling edge, held while stalled;
    // receiver stall drawn here too, with occasional stretches of no idling
    always @(negedge i_clk) begin : word_driver
        logic                 nxt_valid;
        logic [TIME_BITS-1:0] nxt_delta;
        logic                 quiet;
        nxt_valid = i_in_valid;
        nxt_delta = i_delta_us;
        quiet     = (quiet_left != 0);
        if (quiet)
            quiet_left--;
        else if ($urandom_range(0, 199) == 0)
            quiet_left = $urandom_range(16, 96);
        if (i_rst_n) begin
            if (!i_in_valid || delta_taken) begin
                nxt_valid = 1'b0;
                if (delta_q.size() != 0 && (quiet || $urandom_range(0, 99) >= snd_idle_pct)) begin
                    nxt_delta = delta_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            delta_taken = 1'b0;
        end
        i_in_valid  <= nxt_valid;
        i_delta_us  <= nxt_delta;
        i_out_stall <= !quiet && ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // monitor: predicts on every accepted frame mark, checks every accepted report
    always @(posedge i_clk) begin : word_monitor
        t_frame_report want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                frame_reports_q.insert(frame_reports_q.size(), predict_frame(i_delta_us));
                delta_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (frame_reports_q.size() == 0) begin
                    report_mismatch("word with nothing owed", o_ticks_due, 0);
                end else begin
                    want = frame_reports_q.pop_front();
                    if (o_ticks_due !== want.ticks)
                        report_mismatch("ticks_due", o_ticks_due, want.ticks);
                    if (o_frame_rate !== want.rate)
                        report_mismatch("frame_rate", o_frame_rate, want.rate);
                    if (o_rate_updated !== want.updated)
                        report_mismatch("rate_updated", o_rate_updated, want.updated);
                end
                results_seen++;
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin : hang_guard
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("** fixed_step_tick_and_fps_meter: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: zero, exact step, one short, tiny, full scale, bit patterns
        delta_q = '{24'd0, 24'd16667, 24'd16666, 24'd1, TIME_MAX, 24'd0,
                    24'h555555, 24'hAAAAAA};
        settle();

        // zero step counts single microseconds; zero window reports on any elapsed time
        write_reg(CFG_FIXED_STEP, '0);
        write_reg(CFG_RATE_WINDOW, '0);
        delta_q = '{24'd0, 24'd5, TIME_MAX};
        settle();

        // fill the accumulator under the longest step, then shrink the step so
        // the tick count runs past what the output can show
        write_reg(CFG_FIXED_STEP, TIME_MAX);
        write_reg(CFG_RATE_WINDOW, TIME_MAX);
        delta_q = '{TIME_MAX - 24'd1, 24'd0};
        settle();
        write_reg(CFG_FIXED_STEP, 24'd1);
        delta_q = '{TIME_MAX, 24'd3};
        settle();

        // one microsecond window, two microsecond step
        write_reg(CFG_FIXED_STEP, 24'd2);
        write_reg(CFG_RATE_WINDOW, 24'd1);
        delta_q = '{24'd1, 24'd1, 24'd2, 24'd0, 24'd0, 24'd3};
        settle();

        // random part: sender idles lightly and receiver heavily, then swapped, then none
        run_segment(FIXED_STEP_RST, RATE_WINDOW_RST, 27, 59);
        run_segment(24'($urandom_range(1, 255)), 24'($urandom_range(1, 5000)), 27, 59);
        run_segment(24'($urandom_range(0, TIME_MAX)), 24'($urandom_range(0, TIME_MAX)), 59, 27);
        run_segment(TIME_MAX, 24'd1, 59, 27);
        run_segment(24'd1, TIME_MAX, 0, 0);
        run_segment(24'($urandom_range(1000, 40000)), 24'($urandom_range(0, 200000)), 0, 0);

        if (mismatch_cnt == 0)
            $display("** fixed_step_tick_and_fps_meter: PASSED **");
        else
            $display("** fixed_step_tick_and_fps_meter: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fstm_pkg.sv
rtl/core/fstm_ctrl.sv
rtl/core/fstm_dpath.sv
rtl/core/fixed_step_tick_and_fps_meter.sv
tb/sv/tb_fixed_step_tick_and_fps_meter.sv
